// ===== sv/q9sf_pkg.sv =====
// Shared types and constants for the 9-node quadrilateral shape function evaluator.
// Used by the front, queue, back and top modules; depends on nothing.
`default_nettype none

package q9sf_pkg;

   localparam int COORD_W     = 16;             // xi, eta
   localparam int FRAC_BITS   = 14;             // fixed-point scale of inputs and outputs
   localparam int OUT_W       = 18;             // shape value and derivatives
   localparam int NODE_W      = 4;
   localparam int PRIM_W      = 2 * COORD_W;    // quadratic factors a, b, c, d, p, q
   localparam int GRAD_W      = COORD_W + 2;    // linear factors 2x+-1, -x
   localparam int VPROD_W     = 2 * PRIM_W;
   localparam int DPROD_W     = PRIM_W + GRAD_W;
   localparam int SHIFT_W     = 7;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [NODE_W-1:0] {
      NODE_CORNER_PP   = 4'd0,
      NODE_CORNER_MP   = 4'd1,
      NODE_CORNER_MM   = 4'd2,
      NODE_CORNER_PM   = 4'd3,
      NODE_EDGE_TOP    = 4'd4,
      NODE_EDGE_LEFT   = 4'd5,
      NODE_EDGE_BOTTOM = 4'd6,
      NODE_EDGE_RIGHT  = 4'd7,
      NODE_FACE        = 4'd8
   } q9sf_node_type;

   // Factors of one point, shared by all nine nodes
   typedef struct packed {
      logic signed [PRIM_W-1:0] a;     // x(x+1)
      logic signed [PRIM_W-1:0] b;     // e(e+1)
      logic signed [PRIM_W-1:0] c;     // x(x-1)
      logic signed [PRIM_W-1:0] d;     // e(e-1)
      logic signed [PRIM_W-1:0] p;     // 1-x^2
      logic signed [PRIM_W-1:0] q;     // 1-e^2
      logic signed [GRAD_W-1:0] gxp;   // 2x+1
      logic signed [GRAD_W-1:0] gxm;   // 2x-1
      logic signed [GRAD_W-1:0] gep;   // 2e+1
      logic signed [GRAD_W-1:0] gem;   // 2e-1
      logic signed [GRAD_W-1:0] nx;    // -x
      logic signed [GRAD_W-1:0] ne;    // -e
   } q9sf_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q9sf_qstat_type;

endpackage

`default_nettype wire

// ===== sv/q9sf_front.sv =====
// Front end: accepts coordinate words and forms the per-point quadratic and linear factors.
// Depends on q9sf_pkg; writes into q9sf_queue.
`default_nettype none

module q9sf_front (
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [31:0]                  req_tdata,   // xi [15:0], eta [31:16]
   input  q9sf_pkg::q9sf_qstat_type     qstat,
   output logic                         push,
   output q9sf_pkg::q9sf_entry_type     entry
);
   import q9sf_pkg::*;

   localparam logic signed [COORD_W:0]   ONE_X  = (COORD_W+1)'(1 << FRAC_BITS);
   localparam logic signed [PRIM_W-1:0]  ONE_SQ = PRIM_W'(1) << (2 * FRAC_BITS);
   localparam logic signed [GRAD_W-1:0]  ONE_G  = GRAD_W'(1 << FRAC_BITS);

   logic signed [COORD_W-1:0] x, e;
   logic signed [COORD_W:0]   xp, xm, ep, em;
   logic signed [2*COORD_W:0] a_full, b_full, c_full, d_full;
   logic signed [PRIM_W-1:0]  xsq, esq;
   logic signed [GRAD_W-1:0]  x2, e2;

   assign req_tready = !qstat.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      x  = req_tdata[COORD_W-1:0];
      e  = req_tdata[2*COORD_W-1:COORD_W];
      xp = (COORD_W+1)'(x) + ONE_X;
      xm = (COORD_W+1)'(x) - ONE_X;
      ep = (COORD_W+1)'(e) + ONE_X;
      em = (COORD_W+1)'(e) - ONE_X;
      a_full = x * xp;
      c_full = x * xm;
      b_full = e * ep;
      d_full = e * em;
      xsq = x * x;
      esq = e * e;
      x2  = GRAD_W'(x) <<< 1;
      e2  = GRAD_W'(e) <<< 1;

      // every factor fits its field for any 16-bit coordinate
      entry.a   = a_full[PRIM_W-1:0];
      entry.b   = b_full[PRIM_W-1:0];
      entry.c   = c_full[PRIM_W-1:0];
      entry.d   = d_full[PRIM_W-1:0];
      entry.p   = ONE_SQ - xsq;
      entry.q   = ONE_SQ - esq;
      entry.gxp = x2 + ONE_G;
      entry.gxm = x2 - ONE_G;
      entry.gep = e2 + ONE_G;
      entry.gem = e2 - ONE_G;
      entry.nx  = -GRAD_W'(x);
      entry.ne  = -GRAD_W'(e);
   end

endmodule

`default_nettype wire

// ===== sv/q9sf_queue.sv =====
// Short queue of point factors between front and back end.
// Depends on q9sf_pkg.
`default_nettype none

module q9sf_queue #(
   parameter int DEPTH = q9sf_pkg::QUEUE_DEPTH
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  q9sf_pkg::q9sf_entry_type     wr_entry,
   input  wire                          pop,
   output q9sf_pkg::q9sf_entry_type     head,
   output q9sf_pkg::q9sf_qstat_type     qstat
);
   import q9sf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   q9sf_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head        = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== sv/q9sf_back.sv =====
// Back end: steps through the nine nodes of the head point, one node a cycle
// while the output is not stalled, multiplies the factor pairs, rounds and
// saturates, and holds the result word. Depends on q9sf_pkg; reads from q9sf_queue.
`default_nettype none

module q9sf_back (
   input  wire                          clock,
   input  wire                          reset,
   input  q9sf_pkg::q9sf_entry_type     head,
   input  q9sf_pkg::q9sf_qstat_type     qstat,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [55:0]                  rsp_tdata,   // shape_value, d_dxi, d_deta, zero pad
   output logic [3:0]                   rsp_tuser,   // node
   output logic                         rsp_tlast
);
   import q9sf_pkg::*;

   localparam logic signed [VPROD_W-1:0] SAT_HI = VPROD_W'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [VPROD_W-1:0] SAT_LO = -SAT_HI - VPROD_W'(1);
   localparam logic [SHIFT_W-1:0] SH_V_CORNER = SHIFT_W'(3 * FRAC_BITS + 2);
   localparam logic [SHIFT_W-1:0] SH_V_EDGE   = SHIFT_W'(3 * FRAC_BITS + 1);
   localparam logic [SHIFT_W-1:0] SH_V_FACE   = SHIFT_W'(3 * FRAC_BITS);
   localparam logic [SHIFT_W-1:0] SH_D_CORNER = SHIFT_W'(2 * FRAC_BITS + 2);
   localparam logic [SHIFT_W-1:0] SH_D_HIGH   = SHIFT_W'(2 * FRAC_BITS + 1);
   localparam logic [SHIFT_W-1:0] SH_D_LOW    = SHIFT_W'(2 * FRAC_BITS);
   localparam logic [SHIFT_W-1:0] SH_D_FACE   = SHIFT_W'(2 * FRAC_BITS - 1);

   function automatic logic signed [OUT_W-1:0] round_sat(
      input logic signed [VPROD_W-1:0] prod,
      input logic [SHIFT_W-1:0]        k
   );
      logic signed [VPROD_W-1:0] sum;
      logic signed [VPROD_W-1:0] quo;
      sum = prod + (VPROD_W'(1) << (k - SHIFT_W'(1)));
      quo = sum >>> k;
      if (quo > SAT_HI) begin
         return SAT_HI[OUT_W-1:0];
      end else if (quo < SAT_LO) begin
         return SAT_LO[OUT_W-1:0];
      end
      return quo[OUT_W-1:0];
   endfunction

   q9sf_node_type node_ff, node_in;
   logic          issue, m_adv, o_adv;

   // product stage
   logic                       m_vld_ff, m_vld_in;
   q9sf_node_type              m_node_ff;
   logic signed [VPROD_W-1:0]  pv_ff, pv_in;
   logic signed [DPROD_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic signed [PRIM_W-1:0]   fv0, fv1, fx0, fy0;
   logic signed [GRAD_W-1:0]   fx1, fy1;

   // output stage
   logic                       o_vld_ff, o_vld_in;
   q9sf_node_type              o_node_ff;
   logic                       o_last_ff;
   logic signed [OUT_W-1:0]    o_val_ff, o_dx_ff, o_dy_ff;
   logic signed [OUT_W-1:0]    r_val, r_dx, r_dy;
   logic [SHIFT_W-1:0]         kv, kx, ky;

   assign o_adv = !o_vld_ff || rsp_tready;
   assign m_adv = !m_vld_ff || o_adv;
   assign issue = !qstat.empty && m_adv;
   assign pop   = issue && (node_ff == NODE_FACE);

   always_comb begin
      node_in = node_ff;
      if (issue) begin
         node_in = (node_ff == NODE_FACE) ? NODE_CORNER_PP
                                          : q9sf_node_type'(node_ff + NODE_W'(1));
      end
   end

   // factor pairs: value, d/dxi, d/deta
   always_comb begin
      unique case (node_ff)
         NODE_CORNER_PP: begin
            fv0 = head.a; fv1 = head.b; fx0 = head.b; fx1 = head.gxp; fy0 = head.a; fy1 = head.gep;
         end
         NODE_CORNER_MP: begin
            fv0 = head.c; fv1 = head.b; fx0 = head.b; fx1 = head.gxm; fy0 = head.c; fy1 = head.gep;
         end
         NODE_CORNER_MM: begin
            fv0 = head.c; fv1 = head.d; fx0 = head.d; fx1 = head.gxm; fy0 = head.c; fy1 = head.gem;
         end
         NODE_CORNER_PM: begin
            fv0 = head.a; fv1 = head.d; fx0 = head.d; fx1 = head.gxp; fy0 = head.a; fy1 = head.gem;
         end
         NODE_EDGE_TOP: begin
            fv0 = head.b; fv1 = head.p; fx0 = head.b; fx1 = head.nx;  fy0 = head.p; fy1 = head.gep;
         end
         NODE_EDGE_LEFT: begin
            fv0 = head.c; fv1 = head.q; fx0 = head.q; fx1 = head.gxm; fy0 = head.c; fy1 = head.ne;
         end
         NODE_EDGE_BOTTOM: begin
            fv0 = head.d; fv1 = head.p; fx0 = head.d; fx1 = head.nx;  fy0 = head.p; fy1 = head.gem;
         end
         NODE_EDGE_RIGHT: begin
            fv0 = head.a; fv1 = head.q; fx0 = head.q; fx1 = head.gxp; fy0 = head.a; fy1 = head.ne;
         end
         NODE_FACE: begin
            fv0 = head.p; fv1 = head.q; fx0 = head.q; fx1 = head.nx;  fy0 = head.p; fy1 = head.ne;
         end
         default: begin
            fv0 = '0; fv1 = '0; fx0 = '0; fx1 = '0; fy0 = '0; fy1 = '0;
         end
      endcase
      pv_in    = fv0 * fv1;
      px_in    = fx0 * fx1;
      py_in    = fy0 * fy1;
      m_vld_in = m_adv ? issue : m_vld_ff;
   end

   always_comb begin
      unique case (m_node_ff)
         NODE_CORNER_PP, NODE_CORNER_MP, NODE_CORNER_MM, NODE_CORNER_PM: begin
            kv = SH_V_CORNER; kx = SH_D_CORNER; ky = SH_D_CORNER;
         end
         NODE_EDGE_TOP, NODE_EDGE_BOTTOM: begin
            kv = SH_V_EDGE; kx = SH_D_LOW; ky = SH_D_HIGH;
         end
         NODE_EDGE_LEFT, NODE_EDGE_RIGHT: begin
            kv = SH_V_EDGE; kx = SH_D_HIGH; ky = SH_D_LOW;
         end
         NODE_FACE: begin
            kv = SH_V_FACE; kx = SH_D_FACE; ky = SH_D_FACE;
         end
         default: begin
            kv = SH_V_CORNER; kx = SH_D_CORNER; ky = SH_D_CORNER;
         end
      endcase
      r_val    = round_sat(pv_ff, kv);
      r_dx     = round_sat(VPROD_W'(px_ff), kx);
      r_dy     = round_sat(VPROD_W'(py_ff), ky);
      o_vld_in = o_adv ? m_vld_ff : o_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff  <= NODE_CORNER_PP;
         m_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         node_ff  <= node_in;
         m_vld_ff <= m_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         m_node_ff <= node_ff;
         pv_ff     <= pv_in;
         px_ff     <= px_in;
         py_ff     <= py_in;
      end
      if (o_adv && m_vld_ff) begin
         o_node_ff <= m_node_ff;
         o_last_ff <= (m_node_ff == NODE_FACE);
         o_val_ff  <= r_val;
         o_dx_ff   <= r_dx;
         o_dy_ff   <= r_dy;
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = {2'b00, o_dy_ff, o_dx_ff, o_val_ff};
   assign rsp_tuser  = o_node_ff;
   assign rsp_tlast  = o_last_ff;

   a_node_range: assert property (@(posedge clock) disable iff (reset)
      node_ff <= NODE_FACE)
      else $error("node counter out of range");

   a_wrap_after_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> node_ff == NODE_CORNER_PP)
      else $error("node counter did not wrap after the face node");

   a_last_is_face: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == NODE_FACE)))
      else $error("last flag does not match face node");

endmodule

`default_nettype wire

// ===== sv/quad9_shape_function_eval.sv =====
// Evaluates the nine biquadratic (9-node) quadrilateral shape functions and their
// partial derivatives at a point (xi, eta) given in signed Q1.14. Each accepted
// request word yields nine response words in node order: corners (+,+), (-,+),
// (-,-), (+,-), edges (0,+), (-,0), (0,-), (+,0), then the face node, which
// carries tlast. Outputs are signed Q3.14, rounded to nearest with ties upward
// and saturated to 18 bits. The back end issues one node per cycle through a
// single multiply stage and a round/saturate stage while a point is queued and
// the output is not stalled, so the block then sends one response word every
// cycle. Each node's result passes the product registers and then the output
// registers. A queue of QUEUE_DEPTH points lets requests be taken while earlier
// points are still being emitted.
// Depends on q9sf_pkg, q9sf_front, q9sf_queue and q9sf_back.
`default_nettype none

module quad9_shape_function_eval #(
   parameter int QUEUE_DEPTH = q9sf_pkg::QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,    // xi [15:0], eta [31:16]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,    // shape_value [17:0], d_dxi [35:18], d_deta [53:36], zero pad
   output logic [3:0]  rsp_tuser,    // node [3:0]
   output logic        rsp_tlast
);
   import q9sf_pkg::*;

   q9sf_entry_type wr_entry, head;
   q9sf_qstat_type qstat;
   logic           push, pop;

   q9sf_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push),
      .entry      (wr_entry)
   );

   q9sf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (wr_entry),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   q9sf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== bench/q9sf_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the 9-node quadrilateral shape function evaluator: watches both
// streams, predicts nine node words per accepted point and compares in order.
// Depends on q9sf_pkg for the node codes and the fixed-point scale.

module q9sf_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [31:0] req_tdata,    // xi [15:0], eta [31:16]
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [55:0] rsp_tdata,    // shape_value [17:0], d_dxi [35:18], d_deta [53:36], zero pad
   input  wire  [3:0]  rsp_tuser,    // node [3:0]
   input  wire         rsp_tlast,
   output int          mismatch_count,
   output int          words_pending
);
   import q9sf_pkg::*;

   localparam int SAT_MAX = 131071;
   localparam int SAT_MIN = -131072;

   typedef struct packed {
      q9sf_node_type node;
      logic [OUT_W-1:0] shape_value;
      logic [OUT_W-1:0] d_dxi;
      logic [OUT_W-1:0] d_deta;
      logic             last;
   } shape_word_type;

   shape_word_type node_words_due [$];

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Round prod / 2^shift to nearest with ties upward, then clamp to 18 bits
   function automatic logic [OUT_W-1:0] round_to_q3_14(input logic signed [127:0] prod,
                                                        input int shift);
      logic signed [127:0] r;
      r = (prod + (128'sd1 <<< (shift - 1))) >>> shift;
      if (r > SAT_MAX) r = SAT_MAX;
      else if (r < SAT_MIN) r = SAT_MIN;
      return r[OUT_W-1:0];
   endfunction

   function automatic void push_point_results(input logic signed [COORD_W-1:0] xi_in,
                                              input logic signed [COORD_W-1:0] eta_in);
      longint one, x, e, a, b, c, d, p, q, gxp, gxm, gep, gem, nx, ne;
      longint fac [9][6];
      int sh [9][3];
      int f;
      logic signed [127:0] fa, fb;
      logic [OUT_W-1:0] res [3];
      shape_word_type w;
      f   = FRAC_BITS;
      one = longint'(1) <<< f;
      x   = longint'(xi_in);
      e   = longint'(eta_in);
      a   = x * (x + one);
      c   = x * (x - one);
      b   = e * (e + one);
      d   = e * (e - one);
      p   = one * one - x * x;
      q   = one * one - e * e;
      gxp = 2 * x + one;
      gxm = 2 * x - one;
      gep = 2 * e + one;
      gem = 2 * e - one;
      nx  = -x;
      ne  = -e;
      // factor pairs: value, d/dxi, d/deta
      fac[0] = '{a, b, b, gxp, a, gep};
      fac[1] = '{c, b, b, gxm, c, gep};
      fac[2] = '{c, d, d, gxm, c, gem};
      fac[3] = '{a, d, d, gxp, a, gem};
      fac[4] = '{b, p, b, nx,  p, gep};
      fac[5] = '{c, q, q, gxm, c, ne };
      fac[6] = '{d, p, d, nx,  p, gem};
      fac[7] = '{a, q, q, gxp, a, ne };
      fac[8] = '{p, q, q, nx,  p, ne };
      for (int n = 0; n < 4; n++) sh[n] = '{3*f + 2, 2*f + 2, 2*f + 2};
      sh[4] = '{3*f + 1, 2*f,     2*f + 1};
      sh[5] = '{3*f + 1, 2*f + 1, 2*f    };
      sh[6] = '{3*f + 1, 2*f,     2*f + 1};
      sh[7] = '{3*f + 1, 2*f + 1, 2*f    };
      sh[8] = '{3*f,     2*f - 1, 2*f - 1};
      for (int n = 0; n < 9; n++) begin
         for (int j = 0; j < 3; j++) begin
            fa = fac[n][2*j];
            fb = fac[n][2*j + 1];
            res[j] = round_to_q3_14(fa * fb, sh[n][j]);
         end
         w.node        = q9sf_node_type'(n);
         w.shape_value = res[0];
         w.d_dxi       = res[1];
         w.d_deta      = res[2];
         w.last        = (q9sf_node_type'(n) == NODE_FACE);
         node_words_due.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      shape_word_type want;
      if (reset) begin
         node_words_due.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (node_words_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word node=%0d", rsp_tuser));
            end else begin
               want = node_words_due.pop_front();
               if (rsp_tuser != want.node)
                  report_mismatch($sformatf("node got %0d want %0d", rsp_tuser, want.node));
               if (rsp_tdata[17:0] != want.shape_value)
                  report_mismatch($sformatf("node %0d value got %h want %h",
                                            want.node, rsp_tdata[17:0], want.shape_value));
               if (rsp_tdata[35:18] != want.d_dxi)
                  report_mismatch($sformatf("node %0d d_dxi got %h want %h",
                                            want.node, rsp_tdata[35:18], want.d_dxi));
               if (rsp_tdata[53:36] != want.d_deta)
                  report_mismatch($sformatf("node %0d d_deta got %h want %h",
                                            want.node, rsp_tdata[53:36], want.d_deta));
               if (rsp_tdata[55:54] != 2'b00)
                  report_mismatch($sformatf("node %0d pad bits %b", want.node,
                                            rsp_tdata[55:54]));
               if (rsp_tlast != want.last)
                  report_mismatch($sformatf("node %0d tlast got %b want %b",
                                            want.node, rsp_tlast, want.last));
            end
         end
         if (req_tvalid && req_tready)
            push_point_results(req_tdata[15:0], req_tdata[31:16]);
      end
      words_pending = node_words_due.size();
   end

endmodule

// ===== bench/tb_quad9_shape_function_eval.sv =====
`timescale 1ns / 100ps
// Top of the shape function evaluator bench: clock, reset, point stimulus and
// response back-pressure. Depends on quad9_shape_function_eval and q9sf_checker.

module tb_quad9_shape_function_eval;

   localparam int RANDOM_POINTS = 100;
   localparam int QUIET_TAIL    = 30;
   localparam int HOLD_AT_CYCLE = 600;
   localparam int HOLD_CYCLES   = 80;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;     // xi [15:0], eta [31:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;     // shape_value [17:0], d_dxi [35:18], d_deta [53:36], zero pad
   logic [3:0]  rsp_tuser;     // node [3:0]
   logic        rsp_tlast;
   int          mismatch_count;
   int          words_pending;
   bit          quiet_phase;

   quad9_shape_function_eval u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   q9sf_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

   // Offer one point and hold it until taken; maybe idle first
   task automatic send_point(input logic [15:0] xi, input logic [15:0] eta);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {eta, xi};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return 16'(-16384 + 16384 * $urandom_range(0, 2));
         1: return 16'($urandom_range(0, 128) - 64);
         2: return 16'(16384 - $urandom_range(0, 64));
         3: return 16'($urandom_range(0, 64) - 16384);
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   initial begin
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      reset       <= 1'b1;
      quiet_phase = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // corners, edge midpoints, center
      send_point(16'sd0,      16'sd0);
      send_point(16'sd16384,  16'sd16384);
      send_point(-16'sd16384, 16'sd16384);
      send_point(-16'sd16384, -16'sd16384);
      send_point(16'sd16384,  -16'sd16384);
      send_point(16'sd0,      16'sd16384);
      send_point(-16'sd16384, 16'sd0);
      send_point(16'sd0,      -16'sd16384);
      send_point(16'sd16384,  16'sd0);
      // rounding ties and tiny offsets
      send_point(16'sd1,      16'sd1);
      send_point(16'sd1,      -16'sd1);
      send_point(-16'sd1,     16'sd1);
      send_point(16'sd3,      -16'sd5);
      send_point(16'sd8192,   -16'sd8192);
      send_point(-16'sd8192,  16'sd12288);
      send_point(16'sd16383,  -16'sd16383);
      send_point(16'h5555,    16'hAAAA);
      // beyond +-1.0: drives outputs into saturation
      send_point(16'h8000,    16'h8000);
      send_point(16'h7FFF,    16'h7FFF);
      send_point(16'h8000,    16'h7FFF);
      send_point(16'h7FFF,    16'h8000);

      for (int i = 0; i < RANDOM_POINTS; i++) begin
         if (i == RANDOM_POINTS - QUIET_TAIL) quiet_phase = 1'b1;
         send_point(pick_coord(), pick_coord());
      end
      req_tvalid <= 1'b0;

      while (words_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Response back-pressure: random bursts, one long hold, none at the tail
   initial begin
      int cycle_count;
      int idle_left;
      int run_left;
      int hold_left;
      cycle_count = 0;
      idle_left   = 0;
      run_left    = 0;
      hold_left   = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count == HOLD_AT_CYCLE) hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (quiet_phase) begin
            rsp_tready <= 1'b1;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_tready <= 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            idle_left = $urandom_range(1, 5) - 1;
            rsp_tready <= 1'b0;
         end else begin
            run_left = $urandom_range(0, 20);
            rsp_tready <= 1'b1;
         end
      end
   end

endmodule
